/* hw/rtl/sgd_pkg.sv */
// Shared types, sizes and codes for the swipe gesture debouncer.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package sgd_pkg;

   // History depth and timestamp width
   localparam int HIST_DEPTH = 16;
   localparam int TICK_BITS  = 48;
   localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

   // Field widths
   localparam int COORD_W = 12;
   localparam int MOVE_W  = 13;
   localparam int WIN_W   = 32;
   localparam int DEB_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [MOVE_W-1:0] MIN_X_RST    = MOVE_W'(160);
   localparam logic [MOVE_W-1:0] MIN_Y_RST    = MOVE_W'(100);
   localparam logic [WIN_W-1:0]  WINDOW_RST   = WIN_W'(550000);
   localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(1600000);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_X    = 3'd0,
      CSR_MIN_Y    = 3'd1,
      CSR_WINDOW   = 3'd2,
      CSR_DEBOUNCE = 3'd3
   } csr_index_type;

   // Swipe codes
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_DOWN  = 3'd1,
      ACT_UP    = 3'd2,
      ACT_RIGHT = 3'd3,
      ACT_LEFT  = 3'd4
   } action_type;

   // One stored point
   typedef struct packed {
      logic [TICK_BITS-1:0] tick;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } hist_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // latch the accepted beat and push its point
      logic drop;   // discard the expired oldest entry
      logic found;  // take the oldest entry as reference
      logic emit;   // load the result register
   } sgd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_zero;
      logic head_fresh;
      logic out_free;
   } sgd_status_type;

endpackage

`default_nettype wire

/* hw/rtl/sgd_if.sv */
// Channel interfaces of the swipe gesture debouncer: request, response, register write.
// Depends on sgd_pkg for field widths.
`default_nettype none

interface sgd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [sgd_pkg::TICK_BITS-1:0]         now_tick;
   logic                                  point_valid;
   logic [sgd_pkg::COORD_W-1:0]           point_x;
   logic [sgd_pkg::COORD_W-1:0]           point_y;

   modport source (output valid, now_tick, point_valid, point_x, point_y, input ready);
   modport sink   (input valid, now_tick, point_valid, point_x, point_y, output ready);
endinterface

interface sgd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [2:0]                            action;
   logic                                  ref_valid;
   logic [sgd_pkg::COORD_W-1:0]           ref_x;
   logic [sgd_pkg::COORD_W-1:0]           ref_y;

   modport source (output valid, action, ref_valid, ref_x, ref_y, input ready);
   modport sink   (input valid, action, ref_valid, ref_x, ref_y, output ready);
endinterface

interface sgd_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [sgd_pkg::CSR_IDX_W-1:0]         index;
   logic [sgd_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sgd_ctrl.sv */
// Controller of the swipe gesture debouncer: sequences accept, history scan and result.
// Depends on sgd_pkg for the command and status structs.
`default_nettype none

module sgd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sgd_pkg::sgd_status_type status,
   output sgd_pkg::sgd_cmd_type         cmd
);
   import sgd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            // oldest entry is being read
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.count_zero) begin
               state_in = ST_DECIDE;
            end else if (status.head_fresh) begin
               cmd.found = 1'b1;
               state_in  = ST_DECIDE;
            end else begin
               cmd.drop = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sgd_dpath.sv */
// Datapath of the swipe gesture debouncer: registers, point history, expiry and classifier.
// Depends on sgd_pkg; driven by sgd_ctrl through sgd_cmd_type.
`default_nettype none

module sgd_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sgd_pkg::sgd_cmd_type                cmd,
   output sgd_pkg::sgd_status_type                  status,
   // request payload
   input  wire logic [sgd_pkg::TICK_BITS-1:0]       req_now_tick,
   input  wire logic                                req_point_valid,
   input  wire logic [sgd_pkg::COORD_W-1:0]         req_point_x,
   input  wire logic [sgd_pkg::COORD_W-1:0]         req_point_y,
   // response
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_action,
   output logic                                     rsp_ref_valid,
   output logic [sgd_pkg::COORD_W-1:0]              rsp_ref_x,
   output logic [sgd_pkg::COORD_W-1:0]              rsp_ref_y,
   // register writes
   input  wire logic                                csr_write,
   input  wire logic [sgd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sgd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sgd_pkg::*;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HIST_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HIST_DEPTH - 1);

   // Configuration registers
   logic [MOVE_W-1:0] min_x_ff, min_y_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [DEB_W-1:0]  debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff    <= MIN_X_RST;
         min_y_ff    <= MIN_Y_RST;
         window_ff   <= WINDOW_RST;
         debounce_ff <= DEBOUNCE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MIN_X:    min_x_ff    <= csr_data[MOVE_W-1:0];
            CSR_MIN_Y:    min_y_ff    <= csr_data[MOVE_W-1:0];
            CSR_WINDOW:   window_ff   <= csr_data[WIN_W-1:0];
            CSR_DEBOUNCE: debounce_ff <= csr_data[DEB_W-1:0];
            default: ;
         endcase
      end
   end

   // Latched request beat
   logic [TICK_BITS-1:0] now_ff;
   logic                 pv_ff;
   logic [COORD_W-1:0]   px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= req_now_tick;
         pv_ff  <= req_point_valid;
         px_ff  <= req_point_x;
         py_ff  <= req_point_y;
      end
   end

   // Ring pointers
   logic [PTR_W-1:0] head_ff, head_in, head_inc;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_slot, rd_addr;
   logic [PTR_W:0]   slot_sum;
   logic             full;

   assign full     = (count_ff == CNT_FULL);
   assign head_inc = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign slot_sum = {1'b0, head_ff} + (PTR_W+1)'(count_ff);

   // Next free slot, or the oldest one when full
   always_comb begin
      if (full) begin
         wr_slot = head_ff;
      end else if (slot_sum >= (PTR_W+1)'(HIST_DEPTH)) begin
         wr_slot = PTR_W'(slot_sum - (PTR_W+1)'(HIST_DEPTH));
      end else begin
         wr_slot = slot_sum[PTR_W-1:0];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.load && req_point_valid) begin
         if (full) begin
            head_in = head_inc;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.drop) begin
         head_in  = head_inc;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // History memory, one write and one registered read
   hist_entry_type hist_mem [HIST_DEPTH];
   hist_entry_type rd_data_ff;
   hist_entry_type wr_data;

   assign wr_data = '{tick: req_now_tick, x: req_point_x, y: req_point_y};
   // Read ahead past an entry being dropped
   assign rd_addr = cmd.drop ? head_inc : head_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && req_point_valid) begin
         hist_mem[wr_slot] <= wr_data;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // Expiry test on the oldest entry
   logic [TICK_BITS-1:0] age;
   assign age = now_ff - rd_data_ff.tick;

   assign status.count_zero = (count_ff == '0);
   assign status.head_fresh = (rd_data_ff.tick >= now_ff) ||
                              (age < TICK_BITS'(window_ff));
   assign status.out_free   = !rsp_valid || rsp_ready;

   // Reference point
   logic               found_ff;
   logic [COORD_W-1:0] ref_x_ff, ref_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (cmd.found) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.found) begin
         ref_x_ff <= rd_data_ff.x;
         ref_y_ff <= rd_data_ff.y;
      end
   end

   // Classify the displacement
   logic signed [MOVE_W:0] dx, dy, mx, my;
   action_type             cand;
   logic [TICK_BITS-1:0]   last_fire_ff, gap;
   logic                   fire;

   assign dx  = $signed({2'b00, px_ff}) - $signed({2'b00, ref_x_ff});
   assign dy  = $signed({2'b00, py_ff}) - $signed({2'b00, ref_y_ff});
   assign mx  = $signed({1'b0, min_x_ff});
   assign my  = $signed({1'b0, min_y_ff});
   assign gap = now_ff - last_fire_ff;

   always_comb begin
      cand = ACT_NONE;
      if (dy > my) begin
         cand = ACT_DOWN;
      end else if (dy < -my) begin
         cand = ACT_UP;
      end
      if (dx > mx) begin
         cand = ACT_RIGHT;
      end else if (dx < -mx) begin
         cand = ACT_LEFT;
      end
   end

   assign fire = pv_ff && found_ff && (cand != ACT_NONE) &&
                 (now_ff > last_fire_ff) && (gap > TICK_BITS'(debounce_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_fire_ff <= '0;
      end else if (cmd.emit && fire) begin
         last_fire_ff <= now_ff;
      end
   end

   // Result register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_action_ff;
   logic               rsp_ref_valid_ff;
   logic [COORD_W-1:0] rsp_ref_x_ff, rsp_ref_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_action_ff    <= fire ? cand : ACT_NONE;
         rsp_ref_valid_ff <= found_ff;
         rsp_ref_x_ff     <= found_ff ? ref_x_ff : '0;
         rsp_ref_y_ff     <= found_ff ? ref_y_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_ref_valid = rsp_ref_valid_ff;
   assign rsp_ref_x     = rsp_ref_x_ff;
   assign rsp_ref_y     = rsp_ref_y_ff;

endmodule

`default_nettype wire

/* hw/rtl/swipe_gesture_debouncer.sv */
// Top level of the swipe gesture debouncer: joins controller and datapath to the channels.
// Depends on sgd_pkg, sgd_if, sgd_ctrl and sgd_dpath.
//
//   channel   direction  carries                                          beat taken when
//   req_ch    in         now_tick, point_valid, point_x, point_y          valid && ready
//   rsp_ch    out        action, ref_valid, ref_x, ref_y                  valid && ready
//   csr_ch    in         index, data (register write)                     valid && ready
//
// The result is registered once the scan has dropped the expired history entries
// (0 to 16) and the output register is free, and the next request can be taken only
// after that; the scan of the history ring walks one entry a cycle through the registered
// read port of the history memory.
// Reset is synchronous and active high; the history memory itself is not cleared.
// A result waits in the output register while the next request is taken and scanned;
// the item after that holds until the register is free, and req_ch stalls while an item
// is in flight. csr_ch is always ready.
`default_nettype none

module swipe_gesture_debouncer (
   input wire logic   clock,
   input wire logic   reset,
   sgd_req_if.sink    req_ch,
   sgd_rsp_if.source  rsp_ch,
   sgd_csr_if.sink    csr_ch
);
   import sgd_pkg::*;

   sgd_cmd_type    cmd;
   sgd_status_type status;

   assign csr_ch.ready = 1'b1;

   sgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_now_tick    (req_ch.now_tick),
      .req_point_valid (req_ch.point_valid),
      .req_point_x     (req_ch.point_x),
      .req_point_y     (req_ch.point_y),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_action      (rsp_ch.action),
      .rsp_ref_valid   (rsp_ch.ref_valid),
      .rsp_ref_x       (rsp_ch.ref_x),
      .rsp_ref_y       (rsp_ch.ref_y),
      .csr_write       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data)
   );

endmodule

`default_nettype wire

/* tb/sgd_checker.sv */
// Scoreboard for the swipe gesture debouncer: watches the request, response and
// register channels, predicts each result and compares it. Depends on sgd_pkg, sgd_if.
`default_nettype none

module sgd_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   sgd_req_if         req,
   sgd_rsp_if         rsp,
   sgd_csr_if         csr,
   output int unsigned open_frames,
   output int unsigned check_errors
);
   timeunit 1ns;
   timeprecision 1ps;
   import sgd_pkg::*;

   typedef struct packed {
      action_type          action;
      logic                ref_valid;
      logic [COORD_W-1:0]  ref_x;
      logic [COORD_W-1:0]  ref_y;
   } swipe_result_type;

   // Shadow copy of the registers
   logic [MOVE_W-1:0]    min_x;
   logic [MOVE_W-1:0]    min_y;
   logic [WIN_W-1:0]     window;
   logic [DEB_W-1:0]     debounce;

   // Shadow copy of the point history and the fire time
   logic [TICK_BITS-1:0] ring_tick [HIST_DEPTH];
   logic [COORD_W-1:0]   ring_x    [HIST_DEPTH];
   logic [COORD_W-1:0]   ring_y    [HIST_DEPTH];
   int unsigned          ring_head;
   int unsigned          ring_fill;
   logic [TICK_BITS-1:0] last_fire;

   swipe_result_type     awaited_swipes [$];
   int unsigned          mismatches;

   function automatic bit still_fresh(input logic [TICK_BITS-1:0] stamp,
                                      input logic [TICK_BITS-1:0] now);
      if (stamp >= now) return 1'b1;
      return (now - stamp) < TICK_BITS'(window);
   endfunction

   // Push the point, expire old entries, classify against the oldest survivor
   function automatic swipe_result_type next_swipe(input logic [TICK_BITS-1:0] now,
                                                   input logic pv,
                                                   input logic [COORD_W-1:0] px,
                                                   input logic [COORD_W-1:0] py);
      swipe_result_type r;
      int unsigned      slot;
      int               dx, dy, mx, my, xi, yi, rx, ry;
      action_type       cand;
      r = '0;
      r.action = ACT_NONE;
      if (pv) begin
         if (ring_fill >= HIST_DEPTH) begin
            ring_head = (ring_head + 1) % HIST_DEPTH;
            ring_fill--;
         end
         slot = (ring_head + ring_fill) % HIST_DEPTH;
         ring_tick[slot] = now;
         ring_x[slot] = px;
         ring_y[slot] = py;
         ring_fill++;
      end
      while (ring_fill > 0 && !r.ref_valid) begin
         if (still_fresh(ring_tick[ring_head], now)) begin
            r.ref_valid = 1'b1;
            r.ref_x = ring_x[ring_head];
            r.ref_y = ring_y[ring_head];
         end else begin
            ring_head = (ring_head + 1) % HIST_DEPTH;
            ring_fill--;
         end
      end
      if (pv && r.ref_valid) begin
         xi = px;
         yi = py;
         rx = r.ref_x;
         ry = r.ref_y;
         mx = min_x;
         my = min_y;
         dx = xi - rx;
         dy = yi - ry;
         cand = ACT_NONE;
         if (dy > my) cand = ACT_DOWN;
         else if (dy < -my) cand = ACT_UP;
         // horizontal motion wins over vertical
         if (dx > mx) cand = ACT_RIGHT;
         else if (dx < -mx) cand = ACT_LEFT;
         if (cand != ACT_NONE && now > last_fire &&
             (now - last_fire) > TICK_BITS'(debounce)) begin
            r.action = cand;
            last_fire = now;
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string field,
                                       input logic [COORD_W-1:0] want,
                                       input logic [COORD_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      swipe_result_type want;
      if (reset) begin
         min_x = MIN_X_RST;
         min_y = MIN_Y_RST;
         window = WINDOW_RST;
         debounce = DEBOUNCE_RST;
         ring_head = 0;
         ring_fill = 0;
         last_fire = '0;
         awaited_swipes.delete();
         mismatches = 0;
      end else begin
         // Apply register writes; unknown indexes are dropped
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_MIN_X:    min_x = csr.data[MOVE_W-1:0];
               CSR_MIN_Y:    min_y = csr.data[MOVE_W-1:0];
               CSR_WINDOW:   window = csr.data[WIN_W-1:0];
               CSR_DEBOUNCE: debounce = csr.data[DEB_W-1:0];
               default: ;
            endcase
         end
         // Predict one result per request beat
         if (req.valid && req.ready)
            awaited_swipes.insert(awaited_swipes.size(),
                                  next_swipe(req.now_tick, req.point_valid,
                                             req.point_x, req.point_y));
         // Compare each response beat with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (awaited_swipes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response beat, expected none, actual action %0d",
                        $time, rsp.action);
            end else begin
               want = awaited_swipes.pop_front();
               check_field("action", COORD_W'(want.action), COORD_W'(rsp.action));
               check_field("ref_valid", COORD_W'(want.ref_valid), COORD_W'(rsp.ref_valid));
               check_field("ref_x", want.ref_x, rsp.ref_x);
               check_field("ref_y", want.ref_y, rsp.ref_y);
            end
         end
      end
      open_frames <= awaited_swipes.size();
      check_errors <= mismatches;
   end

endmodule

`default_nettype wire

/* tb/tb_swipe_gesture_debouncer.sv */
// Testbench top for the swipe gesture debouncer: clock, reset, register setup,
// frame stimulus and response pacing. Depends on sgd_pkg, sgd_if and sgd_checker.
`default_nettype none

module tb_swipe_gesture_debouncer;
   timeunit 1ns;
   timeprecision 1ps;
   import sgd_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned LONG_HOLD     = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [TICK_BITS-1:0] TICK_TOP  = '1;

   logic                 clock;
   logic                 reset;
   int unsigned          open_frames;
   int unsigned          check_errors;
   bit                   calm;
   bit                   hold_off_req;
   logic [TICK_BITS-1:0] cur_tick;

   sgd_req_if req_ch();
   sgd_rsp_if rsp_ch();
   sgd_csr_if csr_ch();

   swipe_gesture_debouncer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sgd_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr          (csr_ch),
      .open_frames  (open_frames),
      .check_errors (check_errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Pace the response side: short random stalls, one long hold on request
   initial begin : rsp_pacing
      int unsigned stall_left;
      bit          hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && hold_off_req && !hold_taken) begin
            stall_left = LONG_HOLD;
            hold_taken = 1'b1;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [COORD_W-1:0] fit_coord(input int c);
      if (c < 0) return '0;
      if (c > 4095) return '1;
      return COORD_W'(c);
   endfunction

   // Offer one frame beat, with an occasional idle burst first; hold until taken
   task automatic send_frame(input logic [TICK_BITS-1:0] t, input logic pv,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.now_tick <= t;
      req_ch.point_valid <= pv;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // Drop valid, wait for every predicted result, then let the block go quiet
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (open_frames == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= d;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [MOVE_W-1:0] mx, input logic [MOVE_W-1:0] my,
                                input logic [WIN_W-1:0] win, input logic [DEB_W-1:0] deb);
      drain_pipeline();
      write_reg(CSR_MIN_X, CSR_DATA_W'(mx));
      write_reg(CSR_MIN_Y, CSR_DATA_W'(my));
      write_reg(CSR_WINDOW, CSR_DATA_W'(win));
      write_reg(CSR_DEBOUNCE, CSR_DATA_W'(deb));
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly steady strokes with random content, the rest noise and clock jumps
   task automatic random_phase(input int unsigned frames, input int unsigned step_max,
                               input logic [WIN_W-1:0] win);
      int unsigned left, stroke_len, k;
      int          x0, y0, vx, vy;
      left = frames;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            stroke_len = $urandom_range(3, 8);
            x0 = $urandom_range(0, 4095);
            y0 = $urandom_range(0, 4095);
            vx = int'($urandom_range(0, 600)) - 300;
            vy = int'($urandom_range(0, 600)) - 300;
            if ($urandom_range(0, 2) == 0) vx = 0;
            else if ($urandom_range(0, 1) == 0) vy = 0;
            for (k = 0; k < stroke_len && left > 0; k++) begin
               cur_tick += TICK_BITS'($urandom_range(0, step_max));
               send_frame(cur_tick, 1'b1, fit_coord(x0 + int'(k) * vx),
                          fit_coord(y0 + int'(k) * vy));
               left--;
            end
         end else begin
            case ($urandom_range(0, 9))
               0: cur_tick -= TICK_BITS'($urandom_range(0, step_max));
               1: cur_tick += TICK_BITS'(win);
               default: cur_tick += TICK_BITS'($urandom_range(0, step_max));
            endcase
            send_frame(cur_tick, 1'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            left--;
         end
      end
   endtask

   initial begin : stimulus
      logic [WIN_W-1:0] win;
      calm = 1'b0;
      hold_off_req = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.now_tick <= '0;
      req_ch.point_valid <= 1'b0;
      req_ch.point_x <= '0;
      req_ch.point_y <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_MIN_X;
      csr_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: empty history, self reference, debounce not yet met,
      // a fired down swipe, then a timestamp going backwards
      send_frame(48'd0, 1'b0, 12'd0, 12'd0);
      send_frame(48'd10, 1'b1, 12'd0, 12'd0);
      send_frame(48'd20, 1'b1, 12'd4095, 12'd4095);
      send_frame(48'd2_000_000, 1'b1, 12'd100, 12'd0);
      send_frame(48'd2_100_000, 1'b1, 12'd100, 12'd4095);
      send_frame(48'd2_200_000, 1'b1, 12'd100, 12'd0);
      send_frame(48'd1_000_000, 1'b1, 12'd4095, 12'd0);

      // Zero thresholds, shortest window, no debounce: all four directions
      drain_pipeline();
      write_reg(CSR_SPARE, '1);
      apply_setting('0, '0, WIN_W'(1), '0);
      send_frame(48'd3_000_000, 1'b1, 12'd10, 12'd10);
      send_frame(48'd3_000_000, 1'b1, 12'd5, 12'd20);
      send_frame(48'd3_000_000, 1'b1, 12'd5, 12'd0);
      send_frame(48'd3_000_001, 1'b1, 12'd5, 12'd0);
      send_frame(48'd3_000_001, 1'b1, 12'd5, 12'd4095);
      send_frame(48'd3_000_002, 1'b1, 12'd5, 12'd4095);
      send_frame(48'd3_000_002, 1'b1, 12'd5, 12'd0);
      send_frame(48'd3_000_003, 1'b1, 12'd0, 12'd0);
      send_frame(48'd3_000_003, 1'b1, 12'd4095, 12'd0);
      send_frame(48'd3_000_003, 1'b0, 12'd0, 12'd0);

      // Longest window and debounce: edges of both, top of the tick range
      apply_setting('0, '0, '1, '1);
      send_frame(48'h2_0000_0000, 1'b1, 12'd100, 12'd100);
      send_frame(48'h2_0000_0000, 1'b1, 12'd101, 12'd100);
      send_frame(48'h2_FFFF_FFFE, 1'b1, 12'd102, 12'd100);
      send_frame(48'h3_0000_0000, 1'b1, 12'd50, 12'd100);
      send_frame(TICK_TOP, 1'b1, 12'd4095, 12'd4095);
      send_frame(48'd5, 1'b0, 12'd0, 12'd0);

      // Random phases over several settings; the first one starts with a long hold
      cur_tick = 48'h100_0000_0000;
      apply_setting(MIN_X_RST, MIN_Y_RST, WINDOW_RST, DEBOUNCE_RST);
      hold_off_req = 1'b1;
      random_phase(200, 150_000, WINDOW_RST);

      apply_setting('0, '0, WIN_W'(1), '0);
      random_phase(200, 2, WIN_W'(1));

      apply_setting('1, '1, '1, '1);
      random_phase(150, 1000, '1);

      apply_setting(MOVE_W'(40), MOVE_W'(40), WIN_W'(1000), DEB_W'(100));
      random_phase(200, 150, WIN_W'(1000));

      win = $urandom_range(50, 5000);
      apply_setting(MOVE_W'($urandom_range(0, 600)), MOVE_W'($urandom_range(0, 600)),
                    win, DEB_W'($urandom_range(0, 3000)));
      random_phase(200, win / 4 + 1, win);

      // Final stretch at full rate on both sides
      apply_setting(MOVE_W'(100), MOVE_W'(60), WIN_W'(2000), DEB_W'(500));
      calm = 1'b1;
      random_phase(250, 400, WIN_W'(2000));

      drain_pipeline();
      if (check_errors == 0 && open_frames == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

/* swipe_gesture_debouncer.f */
hw/rtl/sgd_pkg.sv
hw/rtl/sgd_if.sv
hw/rtl/sgd_ctrl.sv
hw/rtl/sgd_dpath.sv
hw/rtl/swipe_gesture_debouncer.sv
tb/sgd_checker.sv
tb/tb_swipe_gesture_debouncer.sv
